>>> rtl/rrps_pkg.sv
package rrps_pkg;

  localparam int unsigned READY_DEPTH_DEF = 16;
  localparam int unsigned OP_W            = 3;
  localparam int unsigned ID_W            = 8;
  localparam int unsigned BURST_W         = 16;
  localparam int unsigned STATUS_W        = 2;
  localparam int unsigned TICK_W          = 32;
  localparam int unsigned QUANTUM_W       = 16;
  localparam logic [QUANTUM_W-1:0] QUANTUM_RST = 16'd4;

  typedef enum logic [OP_W-1:0] {
    OP_ADMIT    = 3'd0,
    OP_START    = 3'd1,
    OP_EXECUTE  = 3'd2,
    OP_IO_BEGIN = 3'd3,
    OP_IO_END   = 3'd4
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK      = 2'd0,
    STS_ILLEGAL = 2'd1,
    STS_FULL    = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_FETCH,
    S_LOAD,
    S_RESP
  } fsm_e;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [BURST_W-1:0] left;
  } entry_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic fetch;
    logic load;
  } rrps_cmd_t;

  typedef struct packed {
    logic need_pop;
  } rrps_sts_t;

endpackage

>>> rtl/rrps_if.sv
interface rrps_cmd_if import rrps_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    operation;
  logic [ID_W-1:0]    task_id;
  logic [BURST_W-1:0] burst_length;

  modport source (output valid, output operation, output task_id, output burst_length,
                  input ready);
  modport sink   (input valid, input operation, input task_id, input burst_length,
                  output ready);
endinterface

interface rrps_res_if import rrps_pkg::*; #(
  parameter int unsigned CountWidth = 5
) ();
  logic                  valid;
  logic                  ready;
  logic [STATUS_W-1:0]   status;
  logic                  running_valid;
  logic [ID_W-1:0]       running_id;
  logic [BURST_W-1:0]    running_remaining;
  logic                  finished;
  logic [ID_W-1:0]       finished_id;
  logic                  io_pending;
  logic                  all_done;
  logic [CountWidth-1:0] ready_count;
  logic [TICK_W-1:0]     elapsed_ticks;

  modport source (output valid, output status, output running_valid, output running_id,
                  output running_remaining, output finished, output finished_id,
                  output io_pending, output all_done, output ready_count,
                  output elapsed_ticks, input ready);
  modport sink   (input valid, input status, input running_valid, input running_id,
                  input running_remaining, input finished, input finished_id,
                  input io_pending, input all_done, input ready_count,
                  input elapsed_ticks, output ready);
endinterface

interface rrps_cfg_if import rrps_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [QUANTUM_W-1:0] time_quantum;

  modport source (output valid, output time_quantum, input ready);
  modport sink   (input valid, input time_quantum, output ready);
endinterface

>>> rtl/round_robin_process_scheduler_core.sv
// A command is captured in S_IDLE, executed in S_EXEC and answered in S_RESP; when it
// loads the running slot from the ready queue, S_FETCH (a registered memory read) and
// S_LOAD come between. A new command is taken only after the result has been accepted;
// the ready-queue memory has one write and one registered read port.
// Reset: control, counters and quantum (4) clear at once; queue entries are not cleared.
module round_robin_process_scheduler_core import rrps_pkg::*; #(
  parameter int unsigned ReadyDepth = READY_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rrps_cmd_if.sink   cmd_i,
  rrps_cfg_if.sink   cfg_i,
  rrps_res_if.source res_o
);

  localparam int unsigned CntW = $clog2(ReadyDepth + 1);

  rrps_cmd_t          cmd;
  rrps_sts_t          sts;
  logic [CntW-1:0]    ready_count;
  logic [STATUS_W-1:0] status;

  assign cfg_i.ready = 1'b1;

  rrps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (cmd_i.valid),
    .in_ready_o  (cmd_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rrps_dp #(
    .ReadyDepth (ReadyDepth),
    .CntW       (CntW)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .operation_i         (cmd_i.operation),
    .task_id_i           (cmd_i.task_id),
    .burst_length_i      (cmd_i.burst_length),
    .cfg_we_i            (cfg_i.valid),
    .cfg_quantum_i       (cfg_i.time_quantum),
    .status_o            (status),
    .running_valid_o     (res_o.running_valid),
    .running_id_o        (res_o.running_id),
    .running_remaining_o (res_o.running_remaining),
    .finished_o          (res_o.finished),
    .finished_id_o       (res_o.finished_id),
    .io_pending_o        (res_o.io_pending),
    .all_done_o          (res_o.all_done),
    .ready_count_o       (ready_count),
    .elapsed_ticks_o     (res_o.elapsed_ticks)
  );

  assign res_o.status      = status;
  assign res_o.ready_count = ready_count;

endmodule

>>> rtl/rrps_ctrl.sv
module rrps_ctrl import rrps_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  rrps_sts_t sts_i,
  output rrps_cmd_t cmd_o
);

  fsm_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = sts_i.need_pop ? S_FETCH : S_RESP;
      end
      S_FETCH: begin
        state_d = S_LOAD;
      end
      S_LOAD: begin
        state_d = S_RESP;
      end
      S_RESP: begin
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
      end
      S_FETCH: begin
        cmd_o.fetch = 1'b1;
      end
      S_LOAD: begin
        cmd_o.load = 1'b1;
      end
      S_RESP: begin
        out_valid_o = 1'b1;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

>>> rtl/rrps_dp.sv
module rrps_dp import rrps_pkg::*; #(
  parameter int unsigned ReadyDepth = READY_DEPTH_DEF,
  parameter int unsigned CntW       = $clog2(ReadyDepth + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rrps_cmd_t            cmd_i,
  output rrps_sts_t            sts_o,
  input  logic [OP_W-1:0]      operation_i,
  input  logic [ID_W-1:0]      task_id_i,
  input  logic [BURST_W-1:0]   burst_length_i,
  input  logic                 cfg_we_i,
  input  logic [QUANTUM_W-1:0] cfg_quantum_i,
  output logic [STATUS_W-1:0]  status_o,
  output logic                 running_valid_o,
  output logic [ID_W-1:0]      running_id_o,
  output logic [BURST_W-1:0]   running_remaining_o,
  output logic                 finished_o,
  output logic [ID_W-1:0]      finished_id_o,
  output logic                 io_pending_o,
  output logic                 all_done_o,
  output logic [CntW-1:0]      ready_count_o,
  output logic [TICK_W-1:0]    elapsed_ticks_o
);

  localparam int unsigned PtrW = $clog2(ReadyDepth);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(ReadyDepth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(ReadyDepth);

  entry_t mem [ReadyDepth];
  entry_t rd_q;
  entry_t wr_entry;
  logic   wr_en;

  op_e                  op_q;
  logic [ID_W-1:0]      id_in_q;
  logic [BURST_W-1:0]   burst_q;
  logic [QUANTUM_W-1:0] quantum_q;

  status_e              status_q,    status_d;
  logic [ID_W-1:0]      run_id_q,    run_id_d;
  logic [BURST_W-1:0]   run_left_q,  run_left_d;
  logic                 run_valid_q, run_valid_d;
  logic [ID_W-1:0]      wait_id_q,   wait_id_d;
  logic [BURST_W-1:0]   wait_left_q, wait_left_d;
  logic                 wait_valid_q, wait_valid_d;
  logic [QUANTUM_W-1:0] slice_q,     slice_d;
  logic                 started_q,   started_d;
  logic [TICK_W-1:0]    tick_q,      tick_d;
  logic [PtrW-1:0]      head_q,      head_d;
  logic [PtrW-1:0]      tail_q,      tail_d;
  logic [CntW-1:0]      size_q,      size_d;
  logic                 fin_q,       fin_d;
  logic [ID_W-1:0]      fin_id_q,    fin_id_d;
  logic                 rot_q,       rot_d;

  logic [BURST_W-1:0]   left_dec;
  logic [QUANTUM_W-1:0] slice_inc;
  logic                 full;
  logic                 need_pop;

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    return (p == LastPtr) ? '0 : p + 1'b1;
  endfunction

  assign full      = (size_q == FullCnt);
  assign left_dec  = (run_left_q == '0) ? '0 : run_left_q - 1'b1;
  assign slice_inc = slice_q + 1'b1;

  always_comb begin
    status_d     = status_q;
    run_id_d     = run_id_q;
    run_left_d   = run_left_q;
    run_valid_d  = run_valid_q;
    wait_id_d    = wait_id_q;
    wait_left_d  = wait_left_q;
    wait_valid_d = wait_valid_q;
    slice_d      = slice_q;
    started_d    = started_q;
    tick_d       = tick_q;
    head_d       = head_q;
    tail_d       = tail_q;
    size_d       = size_q;
    fin_d        = fin_q;
    fin_id_d     = fin_id_q;
    rot_d        = rot_q;
    wr_en        = 1'b0;
    wr_entry     = '0;
    need_pop     = 1'b0;

    if (cmd_i.exec) begin
      status_d = STS_OK;
      fin_d    = 1'b0;
      fin_id_d = '0;
      rot_d    = 1'b0;
      case (op_q)
        OP_ADMIT: begin
          if (started_q) begin
            status_d = STS_ILLEGAL;
          end else if (full) begin
            status_d = STS_FULL;
          end else begin
            wr_en    = 1'b1;
            wr_entry = '{id: id_in_q, left: burst_q};
            tail_d   = next_ptr(tail_q);
            size_d   = size_q + 1'b1;
          end
        end
        OP_START: begin
          if (started_q) begin
            status_d = STS_ILLEGAL;
          end else begin
            started_d = 1'b1;
            slice_d   = '0;
            if (size_q != '0) begin
              need_pop = 1'b1;
            end else begin
              run_valid_d = 1'b0;
            end
          end
        end
        OP_EXECUTE: begin
          if (!started_q || (!wait_valid_q && !run_valid_q)) begin
            status_d = STS_ILLEGAL;
          end else if (wait_valid_q) begin
            tick_d = tick_q + 1'b1;
          end else begin
            tick_d     = tick_q + 1'b1;
            run_left_d = left_dec;
            if (left_dec == '0) begin
              fin_d       = 1'b1;
              fin_id_d    = run_id_q;
              run_valid_d = 1'b0;
              slice_d     = '0;
              need_pop    = (size_q != '0);
            end else if (slice_inc == quantum_q) begin
              slice_d = '0;
              if (size_q != '0) begin
                rot_d    = 1'b1;
                need_pop = 1'b1;
              end
            end else begin
              slice_d = slice_inc;
            end
          end
        end
        OP_IO_BEGIN: begin
          if (!started_q || wait_valid_q || !run_valid_q) begin
            status_d = STS_ILLEGAL;
          end else begin
            tick_d       = tick_q + 1'b1;
            wait_id_d    = run_id_q;
            wait_left_d  = run_left_q;
            wait_valid_d = 1'b1;
            run_valid_d  = 1'b0;
          end
        end
        OP_IO_END: begin
          if (!started_q || !wait_valid_q) begin
            status_d = STS_ILLEGAL;
          end else begin
            tick_d       = tick_q + 1'b1;
            wait_valid_d = 1'b0;
            slice_d      = '0;
            need_pop     = 1'b1;
            if (!full) begin
              wr_en    = 1'b1;
              wr_entry = '{id: wait_id_q, left: wait_left_q};
              tail_d   = next_ptr(tail_q);
              size_d   = size_q + 1'b1;
            end
          end
        end
        default: begin
          status_d = STS_ILLEGAL;
        end
      endcase
    end

    if (cmd_i.fetch) begin
      head_d = next_ptr(head_q);
      if (rot_q) begin
        wr_en    = 1'b1;
        wr_entry = '{id: run_id_q, left: run_left_q};
        tail_d   = next_ptr(tail_q);
      end else begin
        size_d = size_q - 1'b1;
      end
    end

    if (cmd_i.load) begin
      run_id_d    = rd_q.id;
      run_left_d  = rd_q.left;
      run_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[tail_q] <= wr_entry;
    end
    if (cmd_i.fetch) begin
      rd_q <= mem[head_q];
    end
    if (cmd_i.capture) begin
      op_q    <= op_e'(operation_i);
      id_in_q <= task_id_i;
      burst_q <= burst_length_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quantum_q    <= QUANTUM_RST;
      status_q     <= STS_OK;
      run_id_q     <= '0;
      run_left_q   <= '0;
      run_valid_q  <= 1'b0;
      wait_id_q    <= '0;
      wait_left_q  <= '0;
      wait_valid_q <= 1'b0;
      slice_q      <= '0;
      started_q    <= 1'b0;
      tick_q       <= '0;
      head_q       <= '0;
      tail_q       <= '0;
      size_q       <= '0;
      fin_q        <= 1'b0;
      fin_id_q     <= '0;
      rot_q        <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        quantum_q <= cfg_quantum_i;
      end
      status_q     <= status_d;
      run_id_q     <= run_id_d;
      run_left_q   <= run_left_d;
      run_valid_q  <= run_valid_d;
      wait_id_q    <= wait_id_d;
      wait_left_q  <= wait_left_d;
      wait_valid_q <= wait_valid_d;
      slice_q      <= slice_d;
      started_q    <= started_d;
      tick_q       <= tick_d;
      head_q       <= head_d;
      tail_q       <= tail_d;
      size_q       <= size_d;
      fin_q        <= fin_d;
      fin_id_q     <= fin_id_d;
      rot_q        <= rot_d;
    end
  end

  assign sts_o.need_pop     = need_pop;
  assign status_o           = status_q;
  assign running_valid_o    = run_valid_q;
  assign running_id_o       = run_valid_q ? run_id_q : '0;
  assign running_remaining_o = run_valid_q ? run_left_q : '0;
  assign finished_o         = fin_q;
  assign finished_id_o      = fin_id_q;
  assign io_pending_o       = wait_valid_q;
  assign all_done_o         = started_q && !run_valid_q && !wait_valid_q;
  assign ready_count_o      = size_q;
  assign elapsed_ticks_o    = tick_q;

endmodule
